>>> rtl/dps_pkg.sv
// ============================================================================
// dps_pkg
// Shared types, register indexes and reset values for the debounced press
// sender.
// ============================================================================
package dps_pkg;

	localparam int unsigned SEQ_BITS_DEF   = 16;
	localparam int unsigned TIMER_BITS_DEF = 16;

	localparam int unsigned MS_W      = 16;
	localparam int unsigned SENDER_W  = 32;
	localparam int unsigned RCOUNT_W  = 2;
	localparam int unsigned PSEQ_W    = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_ON_LOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEND_ENABLE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENDER_ID    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_MS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_COUNT  = 3'd6;

	// Opcodes of an input beat.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_MANUAL = 1'b1;

	// Register reset values.
	localparam logic [MS_W-1:0]     DEBOUNCE_MS_RST = 16'd40;
	localparam logic [MS_W-1:0]     RETRY_MS_RST    = 16'd20;
	localparam logic [MS_W-1:0]     COOLDOWN_MS_RST = 16'd1200;
	localparam logic [RCOUNT_W-1:0] RETRY_COUNT_RST = 2'd2;

	typedef struct packed {
		logic                press_on_low;
		logic                send_enable;
		logic [SENDER_W-1:0] sender_id;
		logic [MS_W-1:0]     debounce_ms;
		logic [MS_W-1:0]     retry_ms;
		logic [MS_W-1:0]     cooldown_ms;
		logic [RCOUNT_W-1:0] retry_count;
	} cfg_t;

	typedef struct packed {
		logic opcode;
		logic pin_level;
		logic tick;
	} item_t;

	typedef struct packed {
		logic [PSEQ_W-1:0]   press_seq;
		logic [SENDER_W-1:0] press_sender;
		logic                is_retry;
		logic                is_manual;
	} res_t;

endpackage

>>> rtl/dps_in_if.sv
// ============================================================================
// dps_in_if
// Input channel: one pin sample, tick and opcode per beat.
// ============================================================================
interface dps_in_if;
	logic valid;
	logic ready;
	logic opcode;
	logic pin_level;
	logic tick;

	modport source (output valid, output opcode, output pin_level, output tick, input ready);
	modport sink   (input valid, input opcode, input pin_level, input tick, output ready);
endinterface

>>> rtl/dps_out_if.sv
// ============================================================================
// dps_out_if
// Result channel: one send or retransmission per beat.
// ============================================================================
interface dps_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] press_seq;
	logic [31:0] press_sender;
	logic        is_retry;
	logic        is_manual;

	modport source (output valid, output press_seq, output press_sender,
		output is_retry, output is_manual, input ready);
	modport sink   (input valid, input press_seq, input press_sender,
		input is_retry, input is_manual, output ready);
endinterface

>>> rtl/dps_cfg_if.sv
// ============================================================================
// dps_cfg_if
// Configuration write channel: register index and write data per beat.
// ============================================================================
interface dps_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/dps_cfg_regs.sv
// ============================================================================
// dps_cfg_regs
// Configuration register file, written one register per beat.
// ============================================================================
module dps_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [dps_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [dps_pkg::CFG_DAT_W-1:0]       wr_data,
	output dps_pkg::cfg_t                       cfg
);

	dps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_on_low <= 1'b0;
			cfg_q.send_enable  <= 1'b0;
			cfg_q.sender_id    <= '0;
			cfg_q.debounce_ms  <= dps_pkg::DEBOUNCE_MS_RST;
			cfg_q.retry_ms     <= dps_pkg::RETRY_MS_RST;
			cfg_q.cooldown_ms  <= dps_pkg::COOLDOWN_MS_RST;
			cfg_q.retry_count  <= dps_pkg::RETRY_COUNT_RST;
		end else if (wr_en) begin
			case (wr_index)
				dps_pkg::REG_PRESS_ON_LOW: cfg_q.press_on_low <= wr_data[0];
				dps_pkg::REG_SEND_ENABLE:  cfg_q.send_enable  <= wr_data[0];
				dps_pkg::REG_SENDER_ID:    cfg_q.sender_id    <= wr_data[dps_pkg::SENDER_W-1:0];
				dps_pkg::REG_DEBOUNCE_MS:  cfg_q.debounce_ms  <= wr_data[dps_pkg::MS_W-1:0];
				dps_pkg::REG_RETRY_MS:     cfg_q.retry_ms     <= wr_data[dps_pkg::MS_W-1:0];
				dps_pkg::REG_COOLDOWN_MS:  cfg_q.cooldown_ms  <= wr_data[dps_pkg::MS_W-1:0];
				dps_pkg::REG_RETRY_COUNT:  cfg_q.retry_count  <= wr_data[dps_pkg::RCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/dps_step.sv
// ============================================================================
// dps_step
// Debounce, cooldown and retransmit state with the per-beat update logic.
// ============================================================================
module dps_step #(
	parameter int unsigned SEQ_BITS   = dps_pkg::SEQ_BITS_DEF,
	parameter int unsigned TIMER_BITS = dps_pkg::TIMER_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  dps_pkg::cfg_t cfg,
	input  dps_pkg::item_t item,
	input  logic          item_valid,
	input  logic          go,
	output logic          emit,
	output dps_pkg::res_t res
);

	logic                        last_level_q;
	logic [TIMER_BITS-1:0]       debounce_left_q;
	logic [TIMER_BITS-1:0]       retry_wait_q;
	logic [dps_pkg::RCOUNT_W-1:0] retries_left_q;
	logic [TIMER_BITS-1:0]       cooldown_left_q;
	logic [SEQ_BITS-1:0]         seq_q;

	logic [dps_pkg::MS_W-1:0] deb_ms_nz, rty_ms_nz;
	logic [TIMER_BITS-1:0]    deb_load, rty_load, cd_load;
	logic [SEQ_BITS-1:0]      seq_inc, seq_bump, seq_out;

	// Zero debounce and retry intervals count as one tick.
	assign deb_ms_nz = (cfg.debounce_ms == '0) ? dps_pkg::MS_W'(1) : cfg.debounce_ms;
	assign rty_ms_nz = (cfg.retry_ms == '0) ? dps_pkg::MS_W'(1) : cfg.retry_ms;

	// Loaded intervals saturate at the timer width.
	if (TIMER_BITS >= dps_pkg::MS_W) begin : g_wide_timer
		assign deb_load = TIMER_BITS'(deb_ms_nz);
		assign rty_load = TIMER_BITS'(rty_ms_nz);
		assign cd_load  = TIMER_BITS'(cfg.cooldown_ms);
	end else begin : g_narrow_timer
		assign deb_load = (|deb_ms_nz[dps_pkg::MS_W-1:TIMER_BITS]) ? '1
			: deb_ms_nz[TIMER_BITS-1:0];
		assign rty_load = (|rty_ms_nz[dps_pkg::MS_W-1:TIMER_BITS]) ? '1
			: rty_ms_nz[TIMER_BITS-1:0];
		assign cd_load  = (|cfg.cooldown_ms[dps_pkg::MS_W-1:TIMER_BITS]) ? '1
			: cfg.cooldown_ms[TIMER_BITS-1:0];
	end

	// The sequence number wraps and skips zero.
	assign seq_inc  = seq_q + SEQ_BITS'(1);
	assign seq_bump = (seq_inc == '0) ? SEQ_BITS'(1) : seq_inc;

	logic                         edge_det, deb_exp, rty_exp, fire, retry_due, bump;
	logic                         last_level_d;
	logic [TIMER_BITS-1:0]        deb_d, rw_d, cd_d, deb_t, rw_t, cd_t;
	logic [dps_pkg::RCOUNT_W-1:0] rl_d, rl_dec;
	logic [SEQ_BITS-1:0]          seq_d;

	always_comb begin
		last_level_d = last_level_q;
		deb_d        = debounce_left_q;
		rw_d         = retry_wait_q;
		cd_d         = cooldown_left_q;
		rl_d         = retries_left_q;
		seq_d        = seq_q;
		emit         = 1'b0;
		bump         = 1'b0;
		fire         = 1'b0;
		retry_due    = 1'b0;
		deb_exp      = 1'b0;
		rty_exp      = 1'b0;
		rl_dec       = retries_left_q - dps_pkg::RCOUNT_W'(1);
		edge_det     = item.pin_level != last_level_q;
		deb_t        = edge_det ? deb_load : debounce_left_q;
		cd_t         = cooldown_left_q;
		rw_t         = retry_wait_q;

		if (item.tick) begin
			if (!edge_det && debounce_left_q != '0) begin
				deb_t   = debounce_left_q - TIMER_BITS'(1);
				deb_exp = debounce_left_q == TIMER_BITS'(1);
			end
			if (cooldown_left_q != '0) begin
				cd_t = cooldown_left_q - TIMER_BITS'(1);
			end
			if (retry_wait_q != '0) begin
				rw_t    = retry_wait_q - TIMER_BITS'(1);
				rty_exp = retry_wait_q == TIMER_BITS'(1);
			end
		end

		if (item.opcode == dps_pkg::OP_MANUAL) begin
			// Manual press: only sequence and cooldown move.
			emit = cfg.send_enable;
			bump = 1'b1;
		end else begin
			last_level_d = item.pin_level;
			deb_d        = deb_t;
			cd_d         = cd_t;
			rw_d         = rw_t;
			fire         = deb_exp && (item.pin_level == !cfg.press_on_low) && (cd_t == '0);
			retry_due    = rty_exp && (retries_left_q != '0);
			if (fire) begin
				// A fire beats a retry due on the same tick.
				emit = cfg.send_enable;
				bump = 1'b1;
				rl_d = cfg.retry_count;
				rw_d = rty_load;
			end else if (retry_due) begin
				emit = cfg.send_enable;
				rl_d = rl_dec;
				if (rl_dec != '0) begin
					rw_d = rty_load;
				end
			end
		end

		seq_out = bump ? seq_bump : seq_q;
		if (emit) begin
			seq_d = seq_out;
			cd_d  = cd_load;
		end
	end

	if (SEQ_BITS >= dps_pkg::PSEQ_W) begin : g_seq_wide
		assign res.press_seq = seq_out[dps_pkg::PSEQ_W-1:0];
	end else begin : g_seq_narrow
		assign res.press_seq = dps_pkg::PSEQ_W'(seq_out);
	end
	assign res.press_sender = cfg.sender_id;
	assign res.is_retry     = (item.opcode != dps_pkg::OP_MANUAL) && !fire && retry_due;
	assign res.is_manual    = item.opcode == dps_pkg::OP_MANUAL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q    <= 1'b0;
			debounce_left_q <= '0;
			retry_wait_q    <= '0;
			retries_left_q  <= '0;
			cooldown_left_q <= '0;
			seq_q           <= '0;
		end else if (go && item_valid) begin
			last_level_q    <= last_level_d;
			debounce_left_q <= deb_d;
			retry_wait_q    <= rw_d;
			retries_left_q  <= rl_d;
			cooldown_left_q <= cd_d;
			seq_q           <= seq_d;
		end
	end

	// A sent sequence number is never zero.
	a_seq_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		go && item_valid && emit |-> seq_out != '0)
		else $error("dps_step: zero sequence number sent");

	// Nothing goes out while sending is disabled.
	a_no_send_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.send_enable |-> !emit)
		else $error("dps_step: send while disabled");

	// The sequence only moves with a first send or a manual press.
	a_seq_moves_on_send: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q != $past(seq_q) |-> $past(go && item_valid && emit && !res.is_retry))
		else $error("dps_step: sequence changed without a send");

	// A send always restarts the cooldown.
	a_cooldown_on_send: assert property (@(posedge clk) disable iff (!arst_n)
		go && item_valid && emit |=> cooldown_left_q == $past(cd_load))
		else $error("dps_step: cooldown not reloaded on send");

endmodule

>>> rtl/debounced_press_sender_core.sv
// ============================================================================
// debounced_press_sender_core
// Debounces a button pin, fires presses with cooldown and retransmits each
// debounced press a configured number of times.
// ============================================================================
//
//   Channel  Role    Beat carries
//   -------  ------  ---------------------------------------------------
//   sample   sink    opcode, pin_level, tick
//   press    source  press_seq, press_sender, is_retry, is_manual
//   cfg      sink    index, data (register write, always ready)
//
// The core takes one sample beat in every clock cycle while the press output
// does not stall. A beat is captured in the input register, its state update
// and result are worked out combinationally from that register, and the
// result is loaded into the press output register, from which it is taken.
// Reset clears all timers, the sequence number and both pipeline valid flags,
// and returns the registers to their defaults.
// When the press output stalls, the result register and the input register
// hold, and sample.ready falls only once both are occupied.
//
module debounced_press_sender_core #(
	parameter int unsigned SEQ_BITS   = dps_pkg::SEQ_BITS_DEF,
	parameter int unsigned TIMER_BITS = dps_pkg::TIMER_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	dps_in_if.sink    sample,
	dps_out_if.source press,
	dps_cfg_if.sink   cfg
);

	// Configuration is to be written only while the core is idle (the core does
	// not enforce this), so the registers can feed the datapath directly.
	dps_pkg::cfg_t cfg_cur;

	assign cfg.ready = 1'b1;

	dps_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_cur)
	);

	// Input register. It advances whenever the output register is free or
	// is being drained in this cycle.
	logic           valid_s1;
	dps_pkg::item_t item_s1;
	logic           go;
	logic           emit;
	dps_pkg::res_t  res_d;

	assign go           = !press.valid || press.ready;
	assign sample.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			item_s1.opcode    <= sample.opcode;
			item_s1.pin_level <= sample.pin_level;
			item_s1.tick      <= sample.tick;
		end
	end

	dps_step #(
		.SEQ_BITS   (SEQ_BITS),
		.TIMER_BITS (TIMER_BITS)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_cur),
		.item       (item_s1),
		.item_valid (valid_s1),
		.go         (go),
		.emit       (emit),
		.res        (res_d)
	);

	// Result register. Items that cause no send simply leave it empty.
	logic          out_valid_q;
	dps_pkg::res_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (go && valid_s1 && emit) begin
			out_q <= res_d;
		end
	end

	assign press.valid        = out_valid_q;
	assign press.press_seq    = out_q.press_seq;
	assign press.press_sender = out_q.press_sender;
	assign press.is_retry     = out_q.is_retry;
	assign press.is_manual    = out_q.is_manual;

	// With an empty result register the core must be able to take a beat.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> sample.ready)
		else $error("core: input stalled with empty result register");

	// A result held under stall keeps the input stage from advancing.
	a_hold_s1_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !press.ready && valid_s1 |=> valid_s1 && $stable(item_s1))
		else $error("core: input stage moved during stall");

	// A result appears only for a processed beat.
	a_result_from_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("core: result without an input beat");

endmodule
